/* sv/delta_varint_field_decoder_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the delta varint field decoder
// Short forms for the concurrent checks at the end of the RTL module.
// ----------------------------------------------------------------------------
`ifndef DELTA_VARINT_FIELD_DECODER_ASSERT_SVH
`define DELTA_VARINT_FIELD_DECODER_ASSERT_SVH

// Condition must hold at every clock edge outside reset
`define DVFD_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define DVFD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/dvfd_pkg.sv */
// ----------------------------------------------------------------------------
// Delta varint field decoder package
// Opcodes, result kinds and the per-stage control record of the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package dvfd_pkg;

  // Field kinds carried with each byte
  localparam logic [2:0] OP_ULEB  = 3'd0;
  localparam logic [2:0] OP_SLEB  = 3'd1;
  localparam logic [2:0] OP_REL   = 3'd2;
  localparam logic [2:0] OP_GROW  = 3'd3;
  localparam logic [2:0] OP_GROWT = 3'd4;
  localparam logic [2:0] OP_RAW64 = 3'd5;
  localparam logic [2:0] OP_RAW16 = 3'd6;

  // Varint limits
  localparam logic [63:0] ESCAPE_DELTA     = 64'd268435455;
  localparam logic [3:0]  MAX_VARINT_BYTES = 4'd10;
  localparam logic [3:0]  RAW64_BYTES      = 4'd8;
  localparam logic [3:0]  RAW16_BYTES      = 4'd2;

  // Pipeline shape: base read in stage 0, result leaves from the last stage.
  // A scaled result is final only once it reaches the last stage.
  localparam int PIPE_DEPTH        = 8;
  localparam int LAST_STAGE        = PIPE_DEPTH - 1;
  localparam int SCALE_BUSY_STAGES = 6;

  // How a finished field combines with its slot
  typedef enum logic [1:0] {
    KIND_DIRECT = 2'd0,  // value as decoded
    KIND_ADD    = 2'd1,  // slot plus delta
    KIND_SCALE  = 2'd2   // (slot / scale + delta) * scale
  } kind_t;

  typedef struct packed {
    logic       vld;
    kind_t      kind;
    logic       store;
    logic       overlong;
    logic [2:0] slot;
  } stage_t;

endpackage

`default_nettype wire

/* sv/delta_varint_field_decoder.sv */
// ----------------------------------------------------------------------------
// Delta varint field decoder
// Takes one byte of a LEB128 / raw little-endian stream per clock and gives
// one item per finished field, base values held in a small synchronous
// memory of SLOT_COUNT entries (all zero after reset, no clearing pass).
// Throughput is one byte per cycle while byte_ready is high. Each finished
// field passes through the eight-stage pipeline (PIPE_DEPTH): base read,
// reciprocal multiply for the division by TIME_SCALE, partial-product sums,
// signed add, multiply back by TIME_SCALE. A byte with opcode 2, 3 or 4 waits
// while a stored opcode 4 result for the same slot is still inside the scale
// stages; other slot conflicts are forwarded at full rate. The pipeline
// stalls only when its last stage holds a result and the output register is
// still occupied.
// ----------------------------------------------------------------------------
`default_nettype none

`include "delta_varint_field_decoder_assert.svh"

module delta_varint_field_decoder
  import dvfd_pkg::*;
#(
  parameter int SLOT_COUNT = 8,
  parameter int TIME_SCALE = 10000
) (
  input  logic               clk,
  input  logic               rst,
  // byte input channel
  input  logic               byte_valid,
  output logic               byte_ready,
  input  logic [7:0]         data_byte,
  input  logic [2:0]         opcode,
  input  logic [2:0]         slot,
  input  logic               store,
  // result channel
  output logic               result_valid,
  input  logic               result_ready,
  output logic signed [63:0] value,
  output logic [2:0]         slot_out,
  output logic               overlong
);

  localparam int IdxW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int LgScale = $clog2(TIME_SCALE);
  localparam int ScaleW  = $clog2(TIME_SCALE + 1);
  localparam int ProdW   = 150;
  // ceil(2^(64+L) / TIME_SCALE): exact quotient for any 64-bit dividend
  localparam logic [ProdW-1:0] RecipFull =
    ((ProdW'(1) << (64 + LgScale)) + ProdW'(TIME_SCALE) - ProdW'(1)) / ProdW'(TIME_SCALE);
  localparam logic [64:0]       RecipM = RecipFull[64:0];
  localparam logic [ScaleW-1:0] ScaleK = ScaleW'(TIME_SCALE);

  // slot modulo SLOT_COUNT on a 3-bit value
  function automatic logic [IdxW-1:0] slot_index(input logic [2:0] s);
    logic [6:0] r;
    r = {4'd0, s};
    for (int i = 0; i < 8; i++) begin
      if (r >= 7'(SLOT_COUNT)) r = r - 7'(SLOT_COUNT);
    end
    return IdxW'(r);
  endfunction

  // field state
  logic [63:0] acc, acc_next;
  logic [6:0]  bit_pos, bit_pos_next;
  logic [3:0]  byte_cnt, byte_cnt_next;
  logic        esc, esc_next;

  // front end
  logic            fire, adv, hazard, scale_busy;
  logic [IdxW-1:0] in_idx;
  logic            emit, emit_bad;
  kind_t           emit_kind;
  logic [63:0]     emit_val;
  stage_t          new_ctl;

  // pipeline
  stage_t          ctl_q [PIPE_DEPTH];
  logic [63:0]     val_q [PIPE_DEPTH];
  logic [IdxW-1:0] idx_q [PIPE_DEPTH];

  // base memory and forwarding
  logic [63:0]           base_mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] slot_written;
  logic [63:0]           rd_data, base_f, lw_val;
  logic                  rd_hit, lw_vld, wr_en, fwd_stale;
  logic [IdxW-1:0]       lw_idx;

  // scale datapath
  logic [63:0]         mag_q, qmag_q, q_full;
  logic [4:1]          neg_sr;
  logic [63:0]         pp_ll, pp_hl;
  logic [64:0]         pp_lh, pp_hh;
  logic [96:0]         sa_q, sb_q;
  logic [ProdW-1:0]    prod_sum;
  logic [31+ScaleW:0]  pl_q, ph_q;

  assign in_idx = slot_index(slot);
  assign wr_en  = ctl_q[LAST_STAGE].vld && ctl_q[LAST_STAGE].store;
  assign adv    = !(ctl_q[LAST_STAGE].vld && result_valid && !result_ready);

  // Hold back a base-using byte while a stored scaled result for its slot is unfinished
  always_comb begin
    scale_busy = 1'b0;
    for (int k = 0; k < SCALE_BUSY_STAGES; k++) begin
      if (ctl_q[k].vld && ctl_q[k].store && ctl_q[k].kind == KIND_SCALE &&
          idx_q[k] == in_idx)
        scale_busy = 1'b1;
    end
  end

  assign hazard     = byte_valid && scale_busy &&
                      (opcode == OP_REL || opcode == OP_GROW || opcode == OP_GROWT);
  assign byte_ready = adv && !hazard;
  assign fire       = byte_valid && byte_ready;

  // Byte decode: accumulate, detect field end and escape
  always_comb begin
    logic [63:0] raw_acc, var_or, var_fin, sext;
    logic [6:0]  bit_pos_inc;
    logic [3:0]  byte_cnt_inc, raw_need;
    logic        sgn, grow;

    raw_acc      = (byte_cnt < RAW64_BYTES)
                 ? acc | ({56'd0, data_byte} << {byte_cnt[2:0], 3'b000}) : acc;
    raw_need     = (opcode == OP_RAW64) ? RAW64_BYTES : RAW16_BYTES;
    byte_cnt_inc = byte_cnt + 4'd1;
    bit_pos_inc  = bit_pos + 7'd7;
    var_or       = (bit_pos < 7'd64)
                 ? acc | ({57'd0, data_byte[6:0]} << bit_pos[5:0]) : acc;
    grow         = (opcode == OP_GROW || opcode == OP_GROWT);
    sgn          = (opcode == OP_SLEB || opcode == OP_REL || (grow && esc));
    sext         = (sgn && data_byte[6] && bit_pos_inc < 7'd64)
                 ? ({64{1'b1}} << bit_pos_inc[5:0]) : 64'd0;
    var_fin      = var_or | sext;

    acc_next      = acc;
    bit_pos_next  = bit_pos;
    byte_cnt_next = byte_cnt;
    esc_next      = esc;
    emit          = 1'b0;
    emit_bad      = 1'b0;
    emit_kind     = KIND_DIRECT;
    emit_val      = 64'd0;

    unique case (opcode) inside
      OP_RAW64, OP_RAW16: begin
        if (byte_cnt_inc < raw_need) begin
          acc_next      = raw_acc;
          byte_cnt_next = byte_cnt_inc;
        end else begin
          acc_next      = 64'd0;
          bit_pos_next  = 7'd0;
          byte_cnt_next = 4'd0;
          esc_next      = 1'b0;
          emit          = 1'b1;
          emit_val      = (opcode == OP_RAW16) ? {48'd0, raw_acc[15:0]} : raw_acc;
        end
      end
      OP_ULEB, OP_SLEB, OP_REL, OP_GROW, OP_GROWT: begin
        if (byte_cnt >= MAX_VARINT_BYTES) begin
          // overlong: drop the field, report it
          acc_next      = 64'd0;
          bit_pos_next  = 7'd0;
          byte_cnt_next = 4'd0;
          esc_next      = 1'b0;
          emit          = 1'b1;
          emit_bad      = 1'b1;
        end else if (data_byte[7]) begin
          acc_next      = var_or;
          bit_pos_next  = bit_pos_inc;
          byte_cnt_next = byte_cnt_inc;
        end else if (grow && !esc && var_fin == ESCAPE_DELTA) begin
          // escape: a signed delta follows
          acc_next      = 64'd0;
          bit_pos_next  = 7'd0;
          byte_cnt_next = 4'd0;
          esc_next      = 1'b1;
        end else begin
          acc_next      = 64'd0;
          bit_pos_next  = 7'd0;
          byte_cnt_next = 4'd0;
          esc_next      = 1'b0;
          emit          = 1'b1;
          emit_val      = var_fin;
          if (opcode == OP_REL || opcode == OP_GROW) emit_kind = KIND_ADD;
          else if (opcode == OP_GROWT)               emit_kind = KIND_SCALE;
          else                                       emit_kind = KIND_DIRECT;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    new_ctl.vld      = fire && emit;
    new_ctl.kind     = emit_kind;
    new_ctl.store    = store && !emit_bad;
    new_ctl.overlong = emit_bad;
    new_ctl.slot     = slot;
  end

  // Field state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      acc      <= '0;
      bit_pos  <= '0;
      byte_cnt <= '0;
      esc      <= 1'b0;
    end else if (fire) begin
      acc      <= acc_next;
      bit_pos  <= bit_pos_next;
      byte_cnt <= byte_cnt_next;
      esc      <= esc_next;
    end
  end

  // Base for stage 0: memory word, then the last write, then younger stages
  always_comb begin
    base_f    = rd_hit ? rd_data : 64'd0;
    fwd_stale = 1'b0;
    if (lw_vld && lw_idx == idx_q[0]) base_f = lw_val;
    for (int k = LAST_STAGE; k >= 1; k--) begin
      if (ctl_q[k].vld && ctl_q[k].store && idx_q[k] == idx_q[0]) begin
        base_f    = val_q[k];
        fwd_stale = (ctl_q[k].kind == KIND_SCALE) && (k != LAST_STAGE);
      end
    end
  end

  // Control of the pipeline stages
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < PIPE_DEPTH; k++) ctl_q[k] <= '0;
    end else if (adv) begin
      ctl_q[0] <= new_ctl;
      for (int k = 1; k < PIPE_DEPTH; k++) ctl_q[k] <= ctl_q[k-1];
    end
  end

  assign prod_sum = ProdW'(sa_q) + (ProdW'(sb_q) << 32);
  assign q_full   = 64'(prod_sum >> (64 + LgScale));

  // Datapath of the stages
  always_ff @(posedge clk) begin
    if (adv) begin
      val_q[0] <= emit_val;
      idx_q[0] <= in_idx;
      for (int k = 1; k < PIPE_DEPTH; k++) idx_q[k] <= idx_q[k-1];
      // stage 0: add to base, magnitude of base for the divide
      val_q[1] <= (ctl_q[0].kind == KIND_ADD) ? base_f + val_q[0] : val_q[0];
      mag_q    <= base_f[63] ? (~base_f + 64'd1) : base_f;
      neg_sr   <= {neg_sr[3:1], base_f[63]};
      // stage 1: partial products of magnitude times reciprocal
      pp_ll    <= mag_q[31:0]  * RecipM[31:0];
      pp_lh    <= mag_q[31:0]  * RecipM[64:32];
      pp_hl    <= mag_q[63:32] * RecipM[31:0];
      pp_hh    <= mag_q[63:32] * RecipM[64:32];
      val_q[2] <= val_q[1];
      // stage 2: fold pairs
      sa_q     <= 97'(pp_ll) + (97'(pp_lh) << 32);
      sb_q     <= 97'(pp_hl) + (97'(pp_hh) << 32);
      val_q[3] <= val_q[2];
      // stage 3: quotient magnitude
      qmag_q   <= q_full;
      val_q[4] <= val_q[3];
      // stage 4: signed quotient plus delta
      if (ctl_q[4].kind == KIND_SCALE)
        val_q[5] <= neg_sr[4] ? val_q[4] - qmag_q : val_q[4] + qmag_q;
      else
        val_q[5] <= val_q[4];
      // stage 5: multiply back by the scale
      pl_q     <= val_q[5][31:0]  * ScaleK;
      ph_q     <= val_q[5][63:32] * ScaleK;
      val_q[6] <= val_q[5];
      // stage 6: combine halves
      if (ctl_q[6].kind == KIND_SCALE)
        val_q[7] <= 64'(pl_q) + {ph_q[31:0], 32'd0};
      else
        val_q[7] <= val_q[6];
    end
  end

  // Base memory: read at accept, write as a result leaves
  always_ff @(posedge clk) begin
    if (adv) begin
      rd_data <= base_mem[in_idx];
      rd_hit  <= slot_written[in_idx];
      lw_idx  <= idx_q[LAST_STAGE];
      lw_val  <= val_q[LAST_STAGE];
      if (wr_en) base_mem[idx_q[LAST_STAGE]] <= val_q[LAST_STAGE];
    end
  end

  // Written flags and last-write tag
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_written <= '0;
      lw_vld       <= 1'b0;
    end else if (adv) begin
      lw_vld <= wr_en;
      if (wr_en) slot_written[idx_q[LAST_STAGE]] <= 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv && ctl_q[LAST_STAGE].vld) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && ctl_q[LAST_STAGE].vld) begin
      value    <= $signed(val_q[LAST_STAGE]);
      slot_out <= ctl_q[LAST_STAGE].slot;
      overlong <= ctl_q[LAST_STAGE].overlong;
    end
  end

  // Checks
  `DVFD_ASSERT_ALWAYS(a_no_stale_base, clk, rst,
    !(ctl_q[0].vld && ctl_q[0].kind != KIND_DIRECT && fwd_stale),
    "base taken from an unfinished scaled result")
  `DVFD_ASSERT_ALWAYS(a_overlong_zero, clk, rst,
    !(result_valid && overlong) || value == 64'sd0,
    "overlong item carries a nonzero value")
  `DVFD_ASSERT_ALWAYS(a_field_bounds, clk, rst,
    byte_cnt <= 4'd11 && bit_pos <= 7'd70,
    "field byte count or bit position out of range")
  `DVFD_ASSERT_NEXT(a_written_sticky, clk, rst, 1'b1,
    (slot_written & $past(slot_written)) == $past(slot_written),
    "slot written flag cleared outside reset")

endmodule

`default_nettype wire
